### rtl/core/rgb_led_panel_scan_driver_defines.svh
// ----------------------------------------------------------------------------
// RGB LED panel scan driver - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_PANEL_SCAN_DRIVER_DEFINES_SVH
`define RGB_LED_PANEL_SCAN_DRIVER_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent
`define RLPSD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlpsd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define RLPSD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rlpsd: next-cycle check failed");

`else

`define RLPSD_ASSERT_SAME(lbl, ante, cons)
`define RLPSD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/rlpsd_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED panel scan driver - shared package
// Request opcodes, colour plane codes and the shifter control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rlpsd_pkg;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_BAR   = 2'd2;

	localparam logic [1:0] PLANE_RED   = 2'd0;
	localparam logic [1:0] PLANE_GREEN = 2'd1;
	localparam logic [1:0] PLANE_BLUE  = 2'd2;

	localparam int NUM_PLANES = 3;

	typedef struct packed {
		logic       load;
		logic [1:0] plane;
		logic       start;
		logic [2:0] row_addr;
	} shift_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/rlpsd_frame_mem.sv
// ----------------------------------------------------------------------------
// RGB LED panel scan driver - frame store
// One row word per plane and pixel row; bit-masked write, two registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpsd_frame_mem #(
	parameter int DEPTH = 48,
	parameter int WIDTH = 32,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_mask,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr_a,
	input  wire logic [AW-1:0]    rd_addr_b,
	output logic      [WIDTH-1:0] rd_data_a,
	output logic      [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (wr_mask[i]) begin
					mem_q[wr_addr][i] <= wr_data[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

`default_nettype wire

### rtl/core/rlpsd_row_shifter.sv
// ----------------------------------------------------------------------------
// RGB LED panel scan driver - row shifter
// Six row shift registers, one bit per cycle unless stalled, onto a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rlpsd_row_shifter
	import rlpsd_pkg::*;
#(
	parameter int WORD_W = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire shift_ctrl_t       ctrl,
	input  wire logic [WORD_W-1:0] upper_word,
	input  wire logic [WORD_W-1:0] lower_word,
	output logic                   busy,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [15:0]            m_axis_tdata,
	output logic                   m_axis_tlast
);

	localparam int CW = $clog2(WORD_W + 1);

	logic [WORD_W-1:0] up_q [NUM_PLANES];
	logic [WORD_W-1:0] lo_q [NUM_PLANES];
	logic [CW-1:0]     cnt_q;
	logic [2:0]        row_q;
	logic              out_valid_q;
	logic [5:0]        pix_q;
	logic [2:0]        out_row_q;
	logic              out_last_q;
	logic              advance;

	assign busy    = (cnt_q != '0);
	assign advance = busy && (!out_valid_q || m_axis_tready);

	// load one plane's pair of row words, shift all six right on advance
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			unique case (ctrl.plane)
				PLANE_RED: begin
					up_q[0] <= upper_word;
					lo_q[0] <= lower_word;
				end
				PLANE_GREEN: begin
					up_q[1] <= upper_word;
					lo_q[1] <= lower_word;
				end
				PLANE_BLUE: begin
					up_q[2] <= upper_word;
					lo_q[2] <= lower_word;
				end
				default: begin
				end
			endcase
		end else if (advance) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				up_q[p] <= up_q[p] >> 1;
				lo_q[p] <= lo_q[p] >> 1;
			end
		end
		if (ctrl.start) begin
			row_q <= ctrl.row_addr;
		end
		if (advance) begin
			pix_q      <= {lo_q[2][0], up_q[2][0], lo_q[1][0], up_q[1][0],
				lo_q[0][0], up_q[0][0]};
			out_row_q  <= row_q;
			out_last_q <= (cnt_q == CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.start) begin
				cnt_q <= CW'(WORD_W);
			end else if (advance) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_row_q, pix_q};
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### rtl/core/rgb_led_panel_scan_driver.sv
// ----------------------------------------------------------------------------
// RGB LED panel scan driver - top level
// Frame store, request sequencer and serial row shifter for an eighth-scan panel.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel; tuser carries the opcode.
// A byte write completes in the cycle it is accepted.
// A column bar sweeps every plane and row of the store, one word write a
// cycle through the single write port.
// A refresh tick reads the six row words plane by plane through the two
// read ports, then shifts them out one bit per cycle while m_axis is not
// stalled: WORD_W results (32 at the defaults), the last one with
// tlast set. The first result is registered after the load sequence has
// started the shifter. The shifter advances only when its output register
// is free, so a stalled receiver simply holds the shift; the next request
// is taken once the shifter has drained, even while its last result still
// waits. After reset the whole store is cleared, during which s_axis_tready
// stays low. The scan row restarts at 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_led_panel_scan_driver_defines.svh"

module rgb_led_panel_scan_driver
	import rlpsd_pkg::*;
#(
	parameter int PANEL_WIDTH  = 32,
	parameter int PANEL_HEIGHT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// plane[1:0], byte_column[3:2], pixel_row[7:4], byte_value[15:8],
	// bar_column[20:16], bar_height[28:21], bar_color[31:29]
	input  wire logic [31:0] s_axis_tdata,
	// opcode[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// red_upper[0], red_lower[1], green_upper[2], green_lower[3],
	// blue_upper[4], blue_lower[5], row_address[8:6], zero[15:9]
	output logic [15:0]      m_axis_tdata,
	// latch_last
	output logic             m_axis_tlast
);

	localparam int COL_BYTES = PANEL_WIDTH / 8;
	localparam int WORD_W    = COL_BYTES * 8;
	localparam int HALF_ROWS = PANEL_HEIGHT / 2;
	localparam int DEPTH     = NUM_PLANES * PANEL_HEIGHT;
	localparam int AW        = $clog2(DEPTH);
	localparam int RW        = $clog2(PANEL_HEIGHT);
	localparam int TW        = $clog2(PANEL_HEIGHT + 1);
	localparam int SW        = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_BAR   = 2'd2;
	localparam logic [1:0] ST_LOAD  = 2'd3;

	// request fields
	logic [1:0] opcode;
	logic [1:0] plane;
	logic [1:0] byte_column;
	logic [3:0] pixel_row;
	logic [7:0] byte_value;
	logic [4:0] bar_column;
	logic [7:0] bar_height;
	logic [2:0] bar_color;

	assign opcode      = s_axis_tuser;
	assign plane       = s_axis_tdata[1:0];
	assign byte_column = s_axis_tdata[3:2];
	assign pixel_row   = s_axis_tdata[7:4];
	assign byte_value  = s_axis_tdata[15:8];
	assign bar_column  = s_axis_tdata[20:16];
	assign bar_height  = s_axis_tdata[28:21];
	assign bar_color   = s_axis_tdata[31:29];

	logic [1:0]    state_q;
	logic [AW-1:0] addr_q;
	logic [RW-1:0] row_q;
	logic [1:0]    plane_q;
	logic [SW-1:0] scan_row_q;
	logic [4:0]    bar_col_q;
	logic [TW-1:0] bar_thr_q;
	logic [2:0]    bar_color_q;

	logic              accept;
	logic              sweep_end;
	logic              shift_busy;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_mask;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] bar_mask;
	logic              bar_set;
	logic              rd_en;
	logic [AW-1:0]     rd_addr_a;
	logic [AW-1:0]     rd_addr_b;
	logic [WORD_W-1:0] rd_data_a;
	logic [WORD_W-1:0] rd_data_b;
	logic              write_ok;
	logic              bar_ok;
	logic [TW-1:0]     bar_thr;
	shift_ctrl_t       ctrl;

	assign s_axis_tready = (state_q == ST_IDLE) && !shift_busy;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign sweep_end     = (addr_q == AW'(DEPTH - 1));

	assign write_ok = (int'(plane) < NUM_PLANES) && (int'(byte_column) < COL_BYTES)
		&& (int'(pixel_row) < PANEL_HEIGHT);
	assign bar_ok   = (int'(bar_column) < WORD_W);
	assign bar_thr  = (int'(bar_height) > PANEL_HEIGHT) ? TW'(0)
		: TW'(PANEL_HEIGHT - int'(bar_height));

	assign bar_mask = WORD_W'(1) << bar_col_q;
	assign bar_set  = (int'(row_q) >= int'(bar_thr_q)) && bar_color_q[plane_q];

	// write port: clearing and bar sweeps, or a byte write straight from the request
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_mask = '1;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_BAR: begin
				wr_en   = 1'b1;
				wr_mask = bar_mask;
				wr_data = bar_set ? bar_mask : '0;
			end
			ST_IDLE: begin
				wr_en   = accept && (opcode == OP_WRITE) && write_ok;
				wr_addr = AW'(int'(plane) * PANEL_HEIGHT + int'(pixel_row));
				wr_mask = WORD_W'(8'hFF) << {byte_column, 3'b000};
				wr_data = {COL_BYTES{byte_value}};
			end
			default: begin
			end
		endcase
	end

	// tick loading: read plane plane_q, load the previously read plane from the registered read data
	assign rd_en     = (state_q == ST_LOAD) && (int'(plane_q) < NUM_PLANES);
	assign rd_addr_a = AW'(int'(plane_q) * PANEL_HEIGHT + int'(scan_row_q));
	assign rd_addr_b = AW'(int'(plane_q) * PANEL_HEIGHT + int'(scan_row_q) + HALF_ROWS);

	assign ctrl.load     = (state_q == ST_LOAD) && (plane_q != 2'd0);
	assign ctrl.plane    = plane_q - 2'd1;
	assign ctrl.start    = (state_q == ST_LOAD) && (int'(plane_q) == NUM_PLANES);
	assign ctrl.row_addr = 3'(scan_row_q);

	always_ff @(posedge clk) begin
		if (accept && (opcode == OP_BAR)) begin
			bar_col_q   <= bar_column;
			bar_thr_q   <= bar_thr;
			bar_color_q <= bar_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			addr_q     <= '0;
			row_q      <= '0;
			plane_q    <= '0;
			scan_row_q <= '0;
		end else begin
			unique case (state_q) inside
				ST_CLEAR, ST_BAR: begin
					if (sweep_end) begin
						state_q <= ST_IDLE;
						addr_q  <= '0;
						row_q   <= '0;
						plane_q <= '0;
					end else begin
						addr_q <= addr_q + AW'(1);
						if (row_q == RW'(PANEL_HEIGHT - 1)) begin
							row_q   <= '0;
							plane_q <= plane_q + 2'd1;
						end else begin
							row_q <= row_q + RW'(1);
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						addr_q  <= '0;
						row_q   <= '0;
						plane_q <= '0;
						case (opcode)
							OP_TICK: state_q <= ST_LOAD;
							OP_BAR:  state_q <= bar_ok ? ST_BAR : ST_IDLE;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOAD: begin
					if (ctrl.start) begin
						state_q <= ST_IDLE;
						plane_q <= '0;
						// advance the scan row once its words are in the shifter
						if (int'(scan_row_q) == HALF_ROWS - 1) begin
							scan_row_q <= '0;
						end else begin
							scan_row_q <= scan_row_q + SW'(1);
						end
					end else begin
						plane_q <= plane_q + 2'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	rlpsd_frame_mem #(
		.DEPTH (DEPTH),
		.WIDTH (WORD_W),
		.AW    (AW)
	) u_frame_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_mask   (wr_mask),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	rlpsd_row_shifter #(
		.WORD_W (WORD_W)
	) u_row_shifter (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.upper_word    (rd_data_a),
		.lower_word    (rd_data_b),
		.busy          (shift_busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// a tick request goes straight into the load sequence
	`RLPSD_ASSERT_NEXT(a_tick_loads, accept && (opcode == OP_TICK), state_q == ST_LOAD)
	// never restart the shifter while it still holds row data
	`RLPSD_ASSERT_SAME(a_start_idle, ctrl.start, !shift_busy)
	// a bar sweep touches exactly one pixel column
	`RLPSD_ASSERT_SAME(a_bar_one_bit, state_q == ST_BAR, wr_en && $onehot(wr_mask))

endmodule

`default_nettype wire
